// ----- rtl/core/twoad_pkg.sv -----
// Shared constants, types and helpers of the three-way odds arbitrage detector.
package twoad_pkg;

   localparam int EVENT_WIDTH         = 32;
   localparam int OUTCOME_WIDTH       = 2;
   localparam int PRICE_WIDTH_DEF     = 26;
   localparam int PRICE_FRAC_BITS_DEF = 16;
   localparam int BOOKIE_WIDTH_DEF    = 16;
   localparam int NUM_OUTCOMES        = 3;
   localparam int LEG_WIDTH           = 2;

   localparam logic [OUTCOME_WIDTH-1:0] OUTCOME_HOME = 2'd0;
   localparam logic [OUTCOME_WIDTH-1:0] OUTCOME_DRAW = 2'd1;
   localparam logic [OUTCOME_WIDTH-1:0] OUTCOME_AWAY = 2'd2;

   localparam logic [LEG_WIDTH-1:0] LEG_FIRST = 2'd0;
   localparam logic [LEG_WIDTH-1:0] LEG_MID   = 2'd1;
   localparam logic [LEG_WIDTH-1:0] LEG_FINAL = 2'd2;

   // multiplier operand selects
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_DA,
      MUL_HA,
      MUL_HD,
      MUL_HD_LO,
      MUL_HD_HI
   } mul_sel_type;

   // what happens to the registered product
   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_LHS_LOAD,
      ACC_LHS_ADD,
      ACC_LHS_ADD_HD,
      ACC_RHS_LOAD,
      ACC_RHS_ADD_HI
   } acc_sel_type;

   typedef struct packed {
      logic        upd;    // fold accepted quote into the bests
      logic        clr;    // drop all kept bests
      logic        snap;   // copy bests into the leg buffer
      mul_sel_type mul;
      acc_sel_type acc;
   } dp_cmd_type;

   // bus width of a word: event, bookie and price, rounded up to bytes
   function automatic int tdata_bits(input int pw, input int bw);
      return ((EVENT_WIDTH + bw + pw + 7) / 8) * 8;
   endfunction

   // legs go out home, away, draw
   function automatic logic [OUTCOME_WIDTH-1:0] leg_outcome(input logic [LEG_WIDTH-1:0] leg);
      logic [OUTCOME_WIDTH-1:0] oc;
      case (leg)
         LEG_FIRST: oc = OUTCOME_HOME;
         LEG_MID:   oc = OUTCOME_AWAY;
         default:   oc = OUTCOME_DRAW;
      endcase
      return oc;
   endfunction

endpackage

// ----- rtl/core/twoad_dp.sv -----
// Datapath: kept best quotes, shared multiplier and the exact arbitrage compare.
module twoad_dp
   import twoad_pkg::*;
#(
   parameter int PRICE_WIDTH     = PRICE_WIDTH_DEF,
   parameter int PRICE_FRAC_BITS = PRICE_FRAC_BITS_DEF,
   parameter int BOOKIE_WIDTH    = BOOKIE_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   input  logic [EVENT_WIDTH-1:0]   in_event,
   input  logic [BOOKIE_WIDTH-1:0]  in_bookie,
   input  logic [OUTCOME_WIDTH-1:0] in_outcome,
   input  logic [PRICE_WIDTH-1:0]   in_price,
   output logic [PRICE_WIDTH-1:0]   best_price[NUM_OUTCOMES],
   output logic [BOOKIE_WIDTH-1:0]  best_bookie[NUM_OUTCOMES],
   output logic [EVENT_WIDTH-1:0]   best_event[NUM_OUTCOMES],
   output logic                     arb
);

   localparam int PROD_W = 2 * PRICE_WIDTH;
   localparam int LHS_W  = 2 * PRICE_WIDTH + 2;
   localparam int RHS_W  = 3 * PRICE_WIDTH;
   localparam int CMP_W  = 3 * PRICE_WIDTH + PRICE_FRAC_BITS + 2;

   logic [PRICE_WIDTH-1:0]  best_price_ff[NUM_OUTCOMES];
   logic [BOOKIE_WIDTH-1:0] best_bookie_ff[NUM_OUTCOMES];
   logic [EVENT_WIDTH-1:0]  best_event_ff[NUM_OUTCOMES];

   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [PROD_W-1:0]      hd_ff;
   logic [LHS_W-1:0]       lhs_ff;
   logic [RHS_W-1:0]       rhs_ff;
   logic [PRICE_WIDTH-1:0] op_x, op_y;
   logic [PRICE_WIDTH-1:0] p_h, p_d, p_a;
   logic [CMP_W-1:0]       lhs_sh, rhs_ext;

   assign p_h = best_price_ff[OUTCOME_HOME];
   assign p_d = best_price_ff[OUTCOME_DRAW];
   assign p_a = best_price_ff[OUTCOME_AWAY];

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_OUTCOMES; i++) begin
         if (reset || cmd.clr) begin
            best_price_ff[i] <= '0;
         end else if (cmd.upd && in_outcome == OUTCOME_WIDTH'(i) &&
                      in_price > best_price_ff[i]) begin
            best_price_ff[i]  <= in_price;
            best_bookie_ff[i] <= in_bookie;
            best_event_ff[i]  <= in_event;
         end
      end
   end

   always_comb begin
      op_x = '0;
      op_y = '0;
      case (cmd.mul)
         MUL_DA:    begin op_x = p_d; op_y = p_a; end
         MUL_HA:    begin op_x = p_h; op_y = p_a; end
         MUL_HD:    begin op_x = p_h; op_y = p_d; end
         MUL_HD_LO: begin op_x = prod_ff[PRICE_WIDTH-1:0]; op_y = p_a; end
         MUL_HD_HI: begin op_x = hd_ff[PROD_W-1:PRICE_WIDTH]; op_y = p_a; end
         default:   begin op_x = '0; op_y = '0; end
      endcase
      prod_in = PROD_W'(op_x) * PROD_W'(op_y);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (cmd.acc)
         ACC_LHS_LOAD:   lhs_ff <= LHS_W'(prod_ff);
         ACC_LHS_ADD:    lhs_ff <= lhs_ff + LHS_W'(prod_ff);
         ACC_LHS_ADD_HD: begin
            lhs_ff <= lhs_ff + LHS_W'(prod_ff);
            hd_ff  <= prod_ff;
         end
         ACC_RHS_LOAD:   rhs_ff <= RHS_W'(prod_ff);
         ACC_RHS_ADD_HI: rhs_ff <= rhs_ff + (RHS_W'(prod_ff) << PRICE_WIDTH);
         default:        ;
      endcase
   end

   // (da + ha + hd) * 2^F < hda, all prices present
   assign lhs_sh  = CMP_W'(lhs_ff) << PRICE_FRAC_BITS;
   assign rhs_ext = CMP_W'(rhs_ff);
   assign arb     = (p_h != '0) && (p_d != '0) && (p_a != '0) && (lhs_sh < rhs_ext);

   assign best_price  = best_price_ff;
   assign best_bookie = best_bookie_ff;
   assign best_event  = best_event_ff;

endmodule

// ----- rtl/core/twoad_legbuf.sv -----
// Result buffer: holds the three legs of a found arbitrage and drives the rsp words.
module twoad_legbuf
   import twoad_pkg::*;
#(
   parameter int PRICE_WIDTH  = PRICE_WIDTH_DEF,
   parameter int BOOKIE_WIDTH = BOOKIE_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  logic [PRICE_WIDTH-1:0]   best_price[NUM_OUTCOMES],
   input  logic [BOOKIE_WIDTH-1:0]  best_bookie[NUM_OUTCOMES],
   input  logic [EVENT_WIDTH-1:0]   best_event[NUM_OUTCOMES],
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // out_event, out_bookie, out_price, zero fill
   output logic [tdata_bits(PRICE_WIDTH, BOOKIE_WIDTH)-1:0] rsp_tdata,
   output logic [OUTCOME_WIDTH-1:0] rsp_tuser,   // out_outcome
   output logic                     rsp_tlast    // last_leg
);

   localparam int TDATA_W = tdata_bits(PRICE_WIDTH, BOOKIE_WIDTH);

   logic [PRICE_WIDTH-1:0]  leg_price_ff[NUM_OUTCOMES];
   logic [BOOKIE_WIDTH-1:0] leg_bookie_ff[NUM_OUTCOMES];
   logic [EVENT_WIDTH-1:0]  leg_event_ff[NUM_OUTCOMES];
   logic                    pend_ff;
   logic [LEG_WIDTH-1:0]    leg_ff;
   logic                    take;

   assign take = pend_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         leg_ff  <= LEG_FIRST;
      end else if (load) begin
         pend_ff <= 1'b1;
         leg_ff  <= LEG_FIRST;
      end else if (take) begin
         if (leg_ff == LEG_FINAL) begin
            pend_ff <= 1'b0;
            leg_ff  <= LEG_FIRST;
         end else begin
            leg_ff <= leg_ff + LEG_WIDTH'(1);
         end
      end
   end

   // stored already in send order
   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < NUM_OUTCOMES; k++) begin
            leg_price_ff[k]  <= best_price[leg_outcome(LEG_WIDTH'(k))];
            leg_bookie_ff[k] <= best_bookie[leg_outcome(LEG_WIDTH'(k))];
            leg_event_ff[k]  <= best_event[leg_outcome(LEG_WIDTH'(k))];
         end
      end
   end

   assign rsp_tvalid = pend_ff;
   assign rsp_tdata  = TDATA_W'({leg_price_ff[leg_ff], leg_bookie_ff[leg_ff],
                                 leg_event_ff[leg_ff]});
   assign rsp_tuser  = leg_outcome(leg_ff);
   assign rsp_tlast  = (leg_ff == LEG_FINAL);

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      load |-> !pend_ff)
      else $error("leg buffer loaded while words still pending");

   a_final_drains: assert property (@(posedge clock) disable iff (reset)
      (take && leg_ff == LEG_FINAL) |=> !pend_ff)
      else $error("leg buffer still valid after final leg taken");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("rsp word changed while stalled");

endmodule

// ----- rtl/core/twoad_ctrl.sv -----
// Controller: quote intake and the multiply/compare sequence after a last quote.
module twoad_ctrl
   import twoad_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   output logic       req_tready,
   input  logic       arb,
   input  logic       buf_busy,
   output dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_M1,
      S_M2,
      S_M3,
      S_M4,
      S_M5,
      S_M6,
      S_CMP
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '{upd: 1'b0, clr: 1'b0, snap: 1'b0, mul: MUL_NONE, acc: ACC_NONE};
      unique case (state_ff)
         S_IDLE: begin
            cmd.upd = accept;
            if (accept && req_tlast) begin
               state_in = S_M1;
            end
         end
         S_M1: begin
            cmd.mul  = MUL_DA;
            state_in = S_M2;
         end
         S_M2: begin
            cmd.mul  = MUL_HA;
            cmd.acc  = ACC_LHS_LOAD;
            state_in = S_M3;
         end
         S_M3: begin
            cmd.mul  = MUL_HD;
            cmd.acc  = ACC_LHS_ADD;
            state_in = S_M4;
         end
         S_M4: begin
            cmd.mul  = MUL_HD_LO;
            cmd.acc  = ACC_LHS_ADD_HD;
            state_in = S_M5;
         end
         S_M5: begin
            cmd.mul  = MUL_HD_HI;
            cmd.acc  = ACC_RHS_LOAD;
            state_in = S_M6;
         end
         S_M6: begin
            cmd.acc  = ACC_RHS_ADD_HI;
            state_in = S_CMP;
         end
         S_CMP: begin
            // hold the bests until the previous legs are gone
            if (!arb) begin
               cmd.clr  = 1'b1;
               state_in = S_IDLE;
            end else if (!buf_busy) begin
               cmd.snap = 1'b1;
               cmd.clr  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_last_starts_check: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (state_ff == S_M1))
      else $error("last quote did not start the check");

   a_snap_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.snap |-> (!buf_busy && arb && cmd.clr))
      else $error("snapshot without room, arbitrage or clear");

   a_no_upd_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.upd |-> !cmd.clr)
      else $error("quote folded in while bests are cleared");

endmodule

// ----- rtl/core/three_way_odds_arbitrage_detector.sv -----
// Top level of the three-way odds arbitrage detector.
//
// req channel: one quote per word, tlast on the final quote of an event.
//   tdata = event, bookie, price; tuser = outcome (0 home, 1 draw, 2 away, 3 ignored).
// rsp channel: three legs per arbitrage, home, away, draw; tlast on the draw leg.
// Quotes are taken one per cycle while the sequencer is idle; each keeps the
// strictly highest price per outcome. After a last quote, req_tready drops while
// one shared multiplier works through five products (da, ha, hd, hd_lo*a, hd_hi*a)
// and the exact compare. When it finds arbitrage, the legs then sit
// in a 3-entry buffer, so new quotes flow while the receiver stalls. A further
// last quote that finds arbitrage waits in the compare step until the buffer empties.
// Reset clears the kept bests, the sequencer and the leg buffer; no words are
// valid afterward and req_tready is already high from the first reset edge on.
module three_way_odds_arbitrage_detector
   import twoad_pkg::*;
#(
   parameter int PRICE_WIDTH     = PRICE_WIDTH_DEF,
   parameter int PRICE_FRAC_BITS = PRICE_FRAC_BITS_DEF,
   parameter int BOOKIE_WIDTH    = BOOKIE_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // event_ident, bookie_ident, price, zero fill
   input  logic [tdata_bits(PRICE_WIDTH, BOOKIE_WIDTH)-1:0] req_tdata,
   input  logic [OUTCOME_WIDTH-1:0] req_tuser,   // outcome_code
   input  logic                     req_tlast,   // last_quote
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // out_event, out_bookie, out_price, zero fill
   output logic [tdata_bits(PRICE_WIDTH, BOOKIE_WIDTH)-1:0] rsp_tdata,
   output logic [OUTCOME_WIDTH-1:0] rsp_tuser,   // out_outcome
   output logic                     rsp_tlast    // last_leg
);

   localparam int BOOKIE_LSB = EVENT_WIDTH;
   localparam int PRICE_LSB  = EVENT_WIDTH + BOOKIE_WIDTH;

   dp_cmd_type              cmd;
   logic                    arb;
   logic [PRICE_WIDTH-1:0]  best_price[NUM_OUTCOMES];
   logic [BOOKIE_WIDTH-1:0] best_bookie[NUM_OUTCOMES];
   logic [EVENT_WIDTH-1:0]  best_event[NUM_OUTCOMES];

   twoad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .arb        (arb),
      .buf_busy   (rsp_tvalid),
      .cmd        (cmd)
   );

   twoad_dp #(
      .PRICE_WIDTH     (PRICE_WIDTH),
      .PRICE_FRAC_BITS (PRICE_FRAC_BITS),
      .BOOKIE_WIDTH    (BOOKIE_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .in_event    (req_tdata[EVENT_WIDTH-1:0]),
      .in_bookie   (req_tdata[BOOKIE_LSB +: BOOKIE_WIDTH]),
      .in_outcome  (req_tuser),
      .in_price    (req_tdata[PRICE_LSB +: PRICE_WIDTH]),
      .best_price  (best_price),
      .best_bookie (best_bookie),
      .best_event  (best_event),
      .arb         (arb)
   );

   twoad_legbuf #(
      .PRICE_WIDTH  (PRICE_WIDTH),
      .BOOKIE_WIDTH (BOOKIE_WIDTH)
   ) u_legbuf (
      .clock       (clock),
      .reset       (reset),
      .load        (cmd.snap),
      .best_price  (best_price),
      .best_bookie (best_bookie),
      .best_event  (best_event),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ----- sim/odds_leg_checker.sv -----
// Checker for the odds arbitrage detector: tracks best quotes, predicts legs, compares.
`timescale 1ns / 100ps
module odds_leg_checker
   import twoad_pkg::*;
#(
   parameter int PW     = PRICE_WIDTH_DEF,
   parameter int FRAC   = PRICE_FRAC_BITS_DEF,
   parameter int BW     = BOOKIE_WIDTH_DEF,
   parameter int DATA_W = tdata_bits(PRICE_WIDTH_DEF, BOOKIE_WIDTH_DEF)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [DATA_W-1:0]        req_tdata,
   input  logic [OUTCOME_WIDTH-1:0] req_tuser,
   input  logic                     req_tlast,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [DATA_W-1:0]        rsp_tdata,
   input  logic [OUTCOME_WIDTH-1:0] rsp_tuser,
   input  logic                     rsp_tlast,
   output int                       fail_count,
   output int                       legs_pending
);

   localparam int BK_LO = EVENT_WIDTH;
   localparam int PR_LO = EVENT_WIDTH + BW;
   localparam logic [OUTCOME_WIDTH-1:0] LEG_ORDER [NUM_OUTCOMES] =
      '{OUTCOME_HOME, OUTCOME_AWAY, OUTCOME_DRAW};

   typedef struct packed {
      logic [EVENT_WIDTH-1:0]   ev;
      logic [BW-1:0]            bk;
      logic [OUTCOME_WIDTH-1:0] oc;
      logic [PW-1:0]            pr;
      logic                     last;
   } leg_type;

   logic [PW-1:0]          best_px  [NUM_OUTCOMES];
   logic [BW-1:0]          best_bk  [NUM_OUTCOMES];
   logic [EVENT_WIDTH-1:0] best_ev  [NUM_OUTCOMES];
   leg_type                legs_due [$];
   int                     errors = 0;

   // exact form of 1/h + 1/d + 1/a < 1 on raw fixed-point prices
   function automatic logic is_surebet(input logic [PW-1:0] h, input logic [PW-1:0] d,
                                       input logic [PW-1:0] a);
      logic [127:0] pair_sum;
      logic [127:0] triple;
      pair_sum = (128'(d) * a + 128'(h) * a + 128'(h) * d) << FRAC;
      triple   = 128'(h) * d * a;
      return pair_sum < triple;
   endfunction

   always @(posedge clock) begin : track
      leg_type                  seen;
      leg_type                  want;
      logic [OUTCOME_WIDTH-1:0] oc;
      logic [PW-1:0]            pr;
      int                       o;
      if (reset) begin
         for (int k = 0; k < NUM_OUTCOMES; k++) begin
            best_px[k] = '0;
            best_bk[k] = '0;
            best_ev[k] = '0;
         end
         legs_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.ev   = rsp_tdata[EVENT_WIDTH-1:0];
            seen.bk   = rsp_tdata[BK_LO +: BW];
            seen.oc   = rsp_tuser;
            seen.pr   = rsp_tdata[PR_LO +: PW];
            seen.last = rsp_tlast;
            if (legs_due.size() == 0) begin
               if (errors < 10)
                  $display("unexpected leg: ev %h bk %h oc %0d pr %h last %b",
                           seen.ev, seen.bk, seen.oc, seen.pr, seen.last);
               errors++;
            end else begin
               want = legs_due.pop_front();
               if (seen.ev != want.ev || seen.bk != want.bk || seen.oc != want.oc ||
                   seen.pr != want.pr || seen.last != want.last) begin
                  if (errors < 10)
                     $display({"leg mismatch: exp ev %h bk %h oc %0d pr %h last %b,",
                               " got ev %h bk %h oc %0d pr %h last %b"},
                              want.ev, want.bk, want.oc, want.pr, want.last,
                              seen.ev, seen.bk, seen.oc, seen.pr, seen.last);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            oc = req_tuser;
            pr = req_tdata[PR_LO +: PW];
            // strictly higher price wins; outcome code 3 is ignored
            if (int'(oc) < NUM_OUTCOMES && pr > best_px[oc]) begin
               best_px[oc] = pr;
               best_bk[oc] = req_tdata[BK_LO +: BW];
               best_ev[oc] = req_tdata[EVENT_WIDTH-1:0];
            end
            if (req_tlast) begin
               if (best_px[OUTCOME_HOME] != 0 && best_px[OUTCOME_DRAW] != 0 &&
                   best_px[OUTCOME_AWAY] != 0 &&
                   is_surebet(best_px[OUTCOME_HOME], best_px[OUTCOME_DRAW],
                              best_px[OUTCOME_AWAY])) begin
                  for (int k = 0; k < NUM_OUTCOMES; k++) begin
                     o         = int'(LEG_ORDER[k]);
                     want.ev   = best_ev[o];
                     want.bk   = best_bk[o];
                     want.oc   = LEG_ORDER[k];
                     want.pr   = best_px[o];
                     want.last = (k == NUM_OUTCOMES - 1);
                     legs_due  = {legs_due, want};
                  end
               end
               for (int k = 0; k < NUM_OUTCOMES; k++) begin
                  best_px[k] = '0;
                  best_bk[k] = '0;
                  best_ev[k] = '0;
               end
            end
         end
      end
      fail_count   <= errors;
      legs_pending <= legs_due.size();
   end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top: drives quote streams into the arbitrage detector and gives the verdict.
`timescale 1ns / 100ps
module tb_top;
   import twoad_pkg::*;

   localparam int PW     = PRICE_WIDTH_DEF;
   localparam int BW     = BOOKIE_WIDTH_DEF;
   localparam int DATA_W = tdata_bits(PRICE_WIDTH_DEF, BOOKIE_WIDTH_DEF);
   localparam int FRAC   = PRICE_FRAC_BITS_DEF;
   localparam int UNIT   = 1 << PRICE_FRAC_BITS_DEF;

   localparam logic [OUTCOME_WIDTH-1:0] OUTCOME_OTHER = 2'd3;
   localparam logic [PW-1:0] PRICE_MAX = '1;

   localparam int RANDOM_QUOTES = 400;
   localparam int DRAIN_CYCLES  = 40;
   localparam int CYCLE_LIMIT   = 200000;

   typedef struct packed {
      logic [EVENT_WIDTH-1:0]   ev;
      logic [BW-1:0]            bk;
      logic [OUTCOME_WIDTH-1:0] oc;
      logic [PW-1:0]            pr;
   } quote_type;

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [DATA_W-1:0]        req_tdata  = '0;   // event_ident, bookie_ident, price, zero fill
   logic [OUTCOME_WIDTH-1:0] req_tuser  = '0;   // outcome_code
   logic                     req_tlast  = 1'b0; // last_quote
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [DATA_W-1:0]        rsp_tdata;         // out_event, out_bookie, out_price, zero fill
   logic [OUTCOME_WIDTH-1:0] rsp_tuser;         // out_outcome
   logic                     rsp_tlast;         // last_leg

   int tx_idle_pct = 30;
   int rx_idle_pct = 55;
   int fail_count;
   int legs_pending;
   int cycles = 0;

   three_way_odds_arbitrage_detector DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   odds_leg_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .fail_count   (fail_count),
      .legs_pending (legs_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // returns after the edge at which the word was taken
   task automatic send_quote(input logic [EVENT_WIDTH-1:0] ev, input logic [BW-1:0] bk,
                             input logic [OUTCOME_WIDTH-1:0] oc, input logic [PW-1:0] pr,
                             input logic last);
      while ($urandom_range(99, 0) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'({pr, bk, ev});
      req_tuser  <= oc;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin : stimulus
      quote_type     book [$];
      quote_type     q;
      logic [127:0]  hd;
      logic [127:0]  pair;
      logic [127:0]  a_thr;
      logic [127:0]  a_val;
      logic [PW-1:0] target [NUM_OUTCOMES];
      logic [31:0]   quote_event;
      int            counted;
      int            n;
      int            k;
      int            off;
      int            dev;
      logic          last;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // extremes: top price everywhere is a surebet
      send_quote(32'hFFFF_FFFF, 16'hFFFF, OUTCOME_HOME, PRICE_MAX, 1'b0);
      send_quote(32'h0, 16'h0, OUTCOME_DRAW, PRICE_MAX, 1'b0);
      send_quote(32'h1234_5678, 16'h00FF, OUTCOME_AWAY, PRICE_MAX, 1'b1);
      // smallest nonzero prices, no surebet
      send_quote(32'h1, 16'h1, OUTCOME_HOME, 26'd1, 1'b0);
      send_quote(32'h1, 16'h2, OUTCOME_DRAW, 26'd1, 1'b0);
      send_quote(32'h1, 16'h3, OUTCOME_AWAY, 26'd1, 1'b1);
      // ties keep the first quote, lower and zero prices never replace, other on last
      send_quote(32'hA5A5_0001, 16'h0011, OUTCOME_HOME, 26'(5 * UNIT), 1'b0);
      send_quote(32'hA5A5_0002, 16'h0022, OUTCOME_HOME, 26'(5 * UNIT), 1'b0);
      send_quote(32'hA5A5_0003, 16'h0033, OUTCOME_DRAW, 26'd0, 1'b0);
      send_quote(32'hA5A5_0004, 16'h0044, OUTCOME_DRAW, 26'(5 * UNIT), 1'b0);
      send_quote(32'hA5A5_0005, 16'h0055, OUTCOME_AWAY, 26'(4 * UNIT), 1'b0);
      send_quote(32'hA5A5_0006, 16'h0066, OUTCOME_AWAY, 26'(5 * UNIT), 1'b0);
      send_quote(32'hA5A5_0007, 16'h0077, OUTCOME_DRAW, 26'(3 * UNIT), 1'b0);
      send_quote(32'hA5A5_0008, 16'h0088, OUTCOME_OTHER, PRICE_MAX, 1'b1);
      // exactly on the boundary: 3.0 each sums to one
      send_quote(32'h3, 16'h3, OUTCOME_HOME, 26'(3 * UNIT), 1'b0);
      send_quote(32'h3, 16'h3, OUTCOME_DRAW, 26'(3 * UNIT), 1'b0);
      send_quote(32'h3, 16'h3, OUTCOME_AWAY, 26'(3 * UNIT), 1'b1);
      // draw quoted only at price zero
      send_quote(32'h4, 16'h4, OUTCOME_HOME, 26'(4 * UNIT), 1'b0);
      send_quote(32'h4, 16'h4, OUTCOME_AWAY, 26'(4 * UNIT), 1'b0);
      send_quote(32'h4, 16'h4, OUTCOME_DRAW, 26'd0, 1'b1);
      // lone ignored quote closing a list
      send_quote(32'h5, 16'h5, OUTCOME_OTHER, 26'(7 * UNIT), 1'b1);
      // one lsb above the boundary
      send_quote(32'h6, 16'h6, OUTCOME_HOME, 26'(3 * UNIT), 1'b0);
      send_quote(32'h6, 16'h6, OUTCOME_DRAW, 26'(3 * UNIT), 1'b0);
      send_quote(32'h6, 16'h6, OUTCOME_AWAY, 26'(3 * UNIT + 1), 1'b1);

      counted = 0;
      while (counted < RANDOM_QUOTES) begin
         if (counted >= 2 * RANDOM_QUOTES / 3) begin
            tx_idle_pct <= 0;
            rx_idle_pct <= 0;
         end else if (counted >= RANDOM_QUOTES / 3) begin
            tx_idle_pct <= 55;
            rx_idle_pct <= 30;
         end
         book.delete();
         quote_event = $urandom;
         if ($urandom_range(99, 0) < 75) begin
            // pick home and draw, then away near the break-even price
            target[OUTCOME_HOME] = PW'($urandom_range(6 * UNIT, 2 * UNIT + 1));
            target[OUTCOME_DRAW] = PW'($urandom_range(6 * UNIT, 2 * UNIT + 1));
            hd   = 128'(target[OUTCOME_HOME]) * target[OUTCOME_DRAW];
            pair = (128'(target[OUTCOME_HOME]) + target[OUTCOME_DRAW]) << FRAC;
            if (hd > pair)
               a_thr = (hd << FRAC) / (hd - pair);
            else
               a_thr = 128'(PRICE_MAX);
            if (a_thr > PRICE_MAX)
               a_thr = 128'(PRICE_MAX);
            off = int'(a_thr >> 4) + 1;
            dev = int'($urandom_range(2 * off, 0));
            if (dev >= off)
               a_val = a_thr + 128'(dev - off);
            else
               a_val = a_thr - 128'(off - dev);
            if (a_val > PRICE_MAX)
               a_val = 128'(PRICE_MAX);
            target[OUTCOME_AWAY] = a_val[PW-1:0];
            for (int o = 0; o < NUM_OUTCOMES; o++) begin
               if ($urandom_range(19, 0) != 0) begin
                  n = int'($urandom_range(3, 1));
                  for (int j = 0; j < n; j++) begin
                     q.ev = ($urandom_range(7, 0) == 0) ? $urandom : quote_event;
                     q.bk = BW'($urandom);
                     q.oc = OUTCOME_WIDTH'(o);
                     q.pr = (j == 0) ? target[o]
                                     : PW'(target[o] - $urandom_range(target[o] >> 3, 0));
                     book = {book, q};
                  end
               end
            end
            if ($urandom_range(3, 0) == 0) begin
               q.ev = quote_event;
               q.bk = BW'($urandom);
               q.oc = OUTCOME_OTHER;
               q.pr = PW'($urandom);
               book = {book, q};
            end
            if ($urandom_range(9, 0) == 0) begin
               q.ev = quote_event;
               q.bk = BW'($urandom);
               q.oc = OUTCOME_WIDTH'($urandom_range(2, 0));
               q.pr = '0;
               book = {book, q};
            end
         end else begin
            // unstructured noise across the full field ranges
            n = int'($urandom_range(6, 1));
            for (int j = 0; j < n; j++) begin
               q.ev = $urandom;
               q.bk = BW'($urandom);
               q.oc = OUTCOME_WIDTH'($urandom_range(3, 0));
               q.pr = PW'($urandom_range(1, 0) ? $urandom : $urandom_range(8 * UNIT, 0));
               book = {book, q};
            end
         end
         if (book.size() == 0) begin
            q.ev = quote_event;
            q.bk = BW'($urandom);
            q.oc = OUTCOME_OTHER;
            q.pr = PW'($urandom);
            book = {book, q};
         end
         for (int j = book.size() - 1; j > 0; j--) begin
            k       = int'($urandom_range(j, 0));
            q       = book[j];
            book[j] = book[k];
            book[k] = q;
         end
         for (int j = 0; j < book.size(); j++) begin
            last = (j == book.size() - 1);
            send_quote(book[j].ev, book[j].bk, book[j].oc, book[j].pr, last);
            if (book[j].oc != OUTCOME_OTHER || last)
               counted++;
         end
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      @(posedge clock);
      while (legs_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && legs_pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
